// File: src/tbq_pkg.sv
// ----------------------------------------------------------------------------
// tbq_pkg
// shared widths, codes and types of the two-bank priority ready queue
// ----------------------------------------------------------------------------
package tbq_pkg;

  // payload field widths, fixed by the channel format
  localparam int MODE_W   = 1;
  localparam int TASK_W   = 8;
  localparam int STATIC_W = 3;
  localparam int DYN_W    = 3;
  localparam int SERVED_W = 2;

  // default sizing of the queue
  localparam int NUM_LEVELS_DEF   = 4;
  localparam int LEVEL_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;

  // beat opcodes
  localparam logic [MODE_W-1:0] MODE_ADD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_TAKE = 1'b1;

  // dynamic level that sends a task to the expired bank
  localparam logic signed [DYN_W-1:0] DYN_EXPIRED = 3'sb111;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } tbq_state_t;

  // per-beat outcome handed from the queue control to the top level
  typedef struct packed {
    logic                found;
    logic                dropped;
    logic [SERVED_W-1:0] served;
  } tbq_status_t;

endpackage

// File: src/tbq_if.sv
// ----------------------------------------------------------------------------
// tbq_req_if / tbq_rsp_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
interface tbq_req_if import tbq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [TASK_W-1:0]          task_id;
  logic [STATIC_W-1:0]        static_level;
  logic signed [DYN_W-1:0]    dynamic_level;

  modport source (
    output valid, mode, task_id, static_level, dynamic_level,
    input  ready
  );
  modport sink (
    input  valid, mode, task_id, static_level, dynamic_level,
    output ready
  );
endinterface

interface tbq_rsp_if import tbq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [TASK_W-1:0]   next_task;
  logic [SERVED_W-1:0] served_level;
  logic                dropped;

  modport source (
    output valid, found, next_task, served_level, dropped,
    input  ready
  );
  modport sink (
    input  valid, found, next_task, served_level, dropped,
    output ready
  );
endinterface

// File: src/tbq_ram.sv
// ----------------------------------------------------------------------------
// tbq_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module tbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: src/tbq_ctrl.sv
// ----------------------------------------------------------------------------
// tbq_ctrl
// per-queue head/tail/count registers, bank select and level pick
// ----------------------------------------------------------------------------
module tbq_ctrl import tbq_pkg::*; #(
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH  = LEVEL_DEPTH_DEF,
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF,
  localparam int LVL_W  = $clog2(NUM_LEVELS),
  localparam int PTR_W  = $clog2(LEVEL_DEPTH),
  localparam int ADDR_W = 1 + LVL_W + PTR_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [MODE_W-1:0]       mode,
  input  logic [TASK_W-1:0]       task_id,
  input  logic [STATIC_W-1:0]     static_level,
  input  logic signed [DYN_W-1:0] dynamic_level,
  output tbq_status_t             status,
  output logic                    ram_we,
  output logic                    ram_re,
  output logic [ADDR_W-1:0]       ram_addr,
  output logic [TASK_ID_BITS-1:0] ram_wdata
);

  localparam int QSLOTS = 2 << LVL_W;
  localparam int Q_W    = 1 + LVL_W;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);

  logic [CNT_W-1:0] counts [QSLOTS];
  logic [PTR_W-1:0] heads  [QSLOTS];
  logic [PTR_W-1:0] tails  [QSLOTS];
  logic             active_bank;

  logic [QSLOTS-1:0] nonempty;
  logic              any_active;
  logic              take_bank;
  logic              hit;
  logic [LVL_W-1:0]  sel_level;
  logic              expired;
  logic              dyn_ok;
  logic              stat_ok;
  logic [LVL_W-1:0]  add_level;
  logic              add_bank;
  logic              add_ok;
  logic              is_take;
  logic [Q_W-1:0]    q;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_inc;

  always_comb begin
    for (int i = 0; i < QSLOTS; i++) begin
      nonempty[i] = counts[i] != '0;
    end

    // banks swap when the active one has nothing queued
    any_active = 1'b0;
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      if (nonempty[{active_bank, LVL_W'(lv)}]) begin
        any_active = 1'b1;
      end
    end
    take_bank = any_active ? active_bank : ~active_bank;

    // highest non-empty level wins
    hit       = 1'b0;
    sel_level = '0;
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      if (nonempty[{take_bank, LVL_W'(lv)}]) begin
        hit       = 1'b1;
        sel_level = LVL_W'(lv);
      end
    end

    expired   = dynamic_level == DYN_EXPIRED;
    dyn_ok    = !dynamic_level[DYN_W-1] && (32'(dynamic_level[DYN_W-2:0]) < NUM_LEVELS);
    stat_ok   = (static_level != '0) && (32'(static_level) <= NUM_LEVELS);
    add_level = expired ? LVL_W'(static_level - STATIC_W'(1))
                        : LVL_W'(dynamic_level[DYN_W-2:0]);
    add_bank  = expired ? ~active_bank : active_bank;

    is_take = mode == MODE_TAKE;
    q       = is_take ? {take_bank, sel_level} : {add_bank, add_level};
    ptr     = is_take ? heads[q] : tails[q];
    ptr_inc = (32'(ptr) == LEVEL_DEPTH - 1) ? '0 : ptr + PTR_W'(1);

    add_ok = (expired ? stat_ok : dyn_ok) && (counts[q] < CNT_W'(LEVEL_DEPTH));

    status.found   = is_take && hit;
    status.dropped = !is_take && !add_ok;
    status.served  = (is_take && hit) ? SERVED_W'(sel_level) : '0;

    ram_we    = go && !is_take && add_ok;
    ram_re    = go && is_take && hit;
    ram_addr  = {q, ptr};
    ram_wdata = TASK_ID_BITS'(task_id);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= 1'b0;
      for (int i = 0; i < QSLOTS; i++) begin
        counts[i] <= '0;
        heads[i]  <= '0;
        tails[i]  <= '0;
      end
    end else if (go) begin
      if (is_take) begin
        active_bank <= take_bank;
        if (hit) begin
          heads[q]  <= ptr_inc;
          counts[q] <= counts[q] - CNT_W'(1);
        end
      end else if (add_ok) begin
        tails[q]  <= ptr_inc;
        counts[q] <= counts[q] + CNT_W'(1);
      end
    end
  end

endmodule

// File: src/two_bank_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// two_bank_priority_ready_queue
// active/expired ready queue of task identifiers with per-level fifos
// ----------------------------------------------------------------------------
// Each request beat either adds a task or takes the next one, and yields
// exactly one result beat. An add with dynamic level -1 goes to the expired
// bank at static level minus one, any other valid dynamic level goes to that
// level of the active bank; an add to a full level or with an out-of-range
// level comes back with dropped set. A take swaps the banks first when the
// active bank is empty, then pops the oldest task of the highest non-empty
// active level. An add's result beat is registered straight from its request
// beat; a take passes through S_READ first, because the popped identifier
// comes out of the task memory's registered read port. A new request is taken
// in the cycle its predecessor's result beat leaves, so with the result side
// never stalling adds run at one beat per cycle, while a take holds off the
// next request in S_READ. There is no clearing pass after reset: the task
// memory is only read at entries the level counts show as filled.
// ----------------------------------------------------------------------------
module two_bank_priority_ready_queue import tbq_pkg::*; #(
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH  = LEVEL_DEPTH_DEF,
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tbq_req_if.sink   req,
  tbq_rsp_if.source rsp
);

  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int PTR_W      = $clog2(LEVEL_DEPTH);
  localparam int ADDR_W     = 1 + LVL_W + PTR_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;

  tbq_state_t state;
  tbq_state_t state_next;

  // result register, holds a beat until the sink takes it
  logic                found;
  logic                dropped;
  logic [SERVED_W-1:0] served_level;
  logic [TASK_W-1:0]   next_task;

  logic                    go;
  tbq_status_t             status;
  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_addr;
  logic [TASK_ID_BITS-1:0] ram_wdata;
  logic [TASK_ID_BITS-1:0] ram_rdata;

  // a fresh request may enter as the previous result beat leaves
  assign req.ready = (state == S_IDLE) || ((state == S_OUT) && rsp.ready);
  assign go        = req.valid && req.ready;

  assign rsp.valid        = state == S_OUT;
  assign rsp.found        = found;
  assign rsp.next_task    = next_task;
  assign rsp.served_level = served_level;
  assign rsp.dropped      = dropped;

  tbq_ctrl #(
    .NUM_LEVELS   (NUM_LEVELS),
    .LEVEL_DEPTH  (LEVEL_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .mode          (req.mode),
    .task_id       (req.task_id),
    .static_level  (req.static_level),
    .dynamic_level (req.dynamic_level),
    .status        (status),
    .ram_we        (ram_we),
    .ram_re        (ram_re),
    .ram_addr      (ram_addr),
    .ram_wdata     (ram_wdata)
  );

  // task identifiers of all queues, addressed by {bank, level, slot}
  tbq_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a take passes through S_READ while the memory read data arrives
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (go) begin
          state_next = (req.mode == MODE_TAKE) ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (go) begin
          state_next = (req.mode == MODE_TAKE) ? S_READ : S_OUT;
        end else if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (go) begin
      found        <= status.found;
      dropped      <= status.dropped;
      served_level <= status.served;
      next_task    <= '0;
    end else if (state == S_READ) begin
      next_task <= found ? TASK_W'(ram_rdata) : '0;
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-bank priority ready queue
// ----------------------------------------------------------------------------
// Drives add and take beats into the request channel and checks every result
// beat against a predictor that tracks the eight level fifos, their pointers
// and counts, and which bank is active. The bench opens with a short directed
// sequence and then runs random phases. Each phase has its own add/take mix,
// so levels fill up and drop adds, and drain until the banks swap. Both sides
// idle at random, and one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import tbq_pkg::*;

  localparam int NL          = NUM_LEVELS_DEF;
  localparam int DEPTH       = LEVEL_DEPTH_DEF;
  localparam int QUEUES      = 2 * NL;
  localparam int RAND_BEATS  = 1900;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 150;
  localparam int PEND_DEPTH  = 64;

  // one request beat as the sender builds it
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [TASK_W-1:0]       task_id;
    logic [STATIC_W-1:0]     static_level;
    logic signed [DYN_W-1:0] dynamic_level;
  } queue_req_t;

  // one result beat, expected or observed
  typedef struct packed {
    logic                found;
    logic [TASK_W-1:0]   next_task;
    logic [SERVED_W-1:0] served_level;
    logic                dropped;
  } queue_rsp_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the run queue state and holds the pending results
  // --------------------------------------------------------------------------
  class run_queue_scoreboard;
    logic [TASK_W-1:0] slots [QUEUES][DEPTH];
    int                head  [QUEUES];
    int                tail  [QUEUES];
    int                fill  [QUEUES];
    bit                bank;
    queue_rsp_t        pending_ring [PEND_DEPTH];
    int                pend_wr;
    int                pend_rd;
    int                mismatches;
    int                n_adds, n_takes, n_drops, n_full_drops, n_none, n_swaps;

    function new();
      foreach (head[q]) begin
        head[q] = 0;
        tail[q] = 0;
        fill[q] = 0;
      end
      bank    = 1'b0;
      pend_wr = 0;
      pend_rd = 0;
    endfunction

    // results noted but not yet seen on the result channel
    function int pending();
      return pend_wr - pend_rd;
    endfunction

    // work out the result of an accepted request and update the mirror
    function void note_request(queue_req_t b);
      queue_rsp_t r;
      int         dyn;
      int         q;
      bit         any;
      r   = '0;
      dyn = $signed(b.dynamic_level);
      if (b.mode == MODE_ADD) begin
        n_adds++;
        q = -1;
        if (b.dynamic_level == DYN_EXPIRED) begin
          // expired bank, level from the static priority
          if (b.static_level >= 1 && b.static_level <= NL)
            q = (bank ^ 1'b1) * NL + b.static_level - 1;
        end else if (dyn >= 0 && dyn < NL) begin
          q = bank * NL + dyn;
        end
        if (q < 0 || fill[q] == DEPTH) begin
          r.dropped = 1'b1;
          n_drops++;
          if (q >= 0) n_full_drops++;
        end else begin
          slots[q][tail[q]] = b.task_id;
          tail[q] = (tail[q] + 1) % DEPTH;
          fill[q]++;
        end
      end else begin
        n_takes++;
        any = 1'b0;
        for (int lv = 0; lv < NL; lv++)
          if (fill[bank * NL + lv] != 0) any = 1'b1;
        if (!any) begin
          bank = ~bank;
          n_swaps++;
        end
        for (int lv = NL - 1; lv >= 0; lv--) begin
          q = bank * NL + lv;
          if (fill[q] != 0) begin
            r.found        = 1'b1;
            r.next_task    = slots[q][head[q]];
            r.served_level = SERVED_W'(lv);
            head[q] = (head[q] + 1) % DEPTH;
            fill[q]--;
            break;
          end
        end
        if (!r.found) n_none++;
      end
      if (pending() == PEND_DEPTH) begin
        $error("too many results pending");
        mismatches++;
      end
      pending_ring[pend_wr % PEND_DEPTH] = r;
      pend_wr++;
    endfunction

    function void check_result(queue_rsp_t got);
      queue_rsp_t want;
      if (pending() == 0) begin
        $error("result beat with nothing pending");
        mismatches++;
        return;
      end
      want = pending_ring[pend_rd % PEND_DEPTH];
      pend_rd++;
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.next_task !== want.next_task) begin
        $error("next_task: expected %0d, got %0d", want.next_task, got.next_task);
        mismatches++;
      end
      if (got.served_level !== want.served_level) begin
        $error("served_level: expected %0d, got %0d", want.served_level,
               got.served_level);
        mismatches++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tbq_req_if req ();
  tbq_rsp_if rsp ();

  two_bank_priority_ready_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #1 clk = ~clk;

  run_queue_scoreboard sb = new();

  // knobs the stimulus flips between phases
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int receiver_hold  = 0;
  int cycle_count    = 0;

  // everything driven to a known value from time zero
  initial begin
    req.valid         = 1'b0;
    req.mode          = MODE_ADD;
    req.task_id       = '0;
    req.static_level  = '0;
    req.dynamic_level = '0;
    rsp.ready         = 1'b0;
  end

  // watchdog: cycle counter with a generous ceiling
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // one request beat: optional idle gap, then hold valid until accepted
  task automatic send_beat(queue_req_t b);
    int gap;
    gap = sender_idles ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.mode          = b.mode;
    req.task_id       = b.task_id;
    req.static_level  = b.static_level;
    req.dynamic_level = b.dynamic_level;
    req.valid         = 1'b1;
    do @(posedge clk); while (!req.ready);
    sb.note_request(b);
  endtask

  function automatic queue_req_t make_beat(logic [MODE_W-1:0] mode, int id,
                                           int slevel, int dlevel);
    queue_req_t b;
    b.mode          = mode;
    b.task_id       = TASK_W'(id);
    b.static_level  = STATIC_W'(slevel);
    b.dynamic_level = DYN_W'(dlevel);
    return b;
  endfunction

  // mostly well-formed beats; about one in ten has levels drawn from all codes
  function automatic queue_req_t random_beat(int add_pct);
    queue_req_t b;
    b.task_id = TASK_W'($urandom_range(0, 255));
    b.mode    = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_TAKE;
    if ($urandom_range(0, 9) == 0) begin
      b.static_level  = STATIC_W'($urandom_range(0, 7));
      b.dynamic_level = DYN_W'($urandom_range(0, 7));
    end else begin
      b.static_level  = STATIC_W'($urandom_range(1, NL));
      // -1 (expired) through the top level
      b.dynamic_level = DYN_W'($urandom_range(0, NL) - 1);
    end
    return b;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    queue_rsp_t got;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (receiver_hold > 0) begin
        gap = receiver_hold;
        receiver_hold = 0;
      end else begin
        gap = receiver_idles ? $urandom_range(0, 8) : 0;
      end
      if (gap > 0) begin
        rsp.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready = 1'b1;
      do @(posedge clk); while (!rsp.valid);
      got.found        = rsp.found;
      got.next_task    = rsp.next_task;
      got.served_level = rsp.served_level;
      got.dropped      = rsp.dropped;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // main stimulus
  initial begin
    queue_req_t directed [24];
    int         n_dir;
    int         sent;
    int         len;
    int         add_pct;
    int         phase;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    n_dir = 0;
    // empty queue: take swaps the banks and finds nothing
    directed[n_dir++] = make_beat(MODE_TAKE, 0, 0, 0);
    // one add per active level, identifier extremes included
    directed[n_dir++] = make_beat(MODE_ADD, 255, 4, 3);
    directed[n_dir++] = make_beat(MODE_ADD, 0, 1, 0);
    directed[n_dir++] = make_beat(MODE_ADD, 17, 2, 1);
    directed[n_dir++] = make_beat(MODE_ADD, 34, 3, 2);
    // static level is ignored on a normal add, even when out of range
    directed[n_dir++] = make_beat(MODE_ADD, 51, 0, 2);
    // expired adds at the lowest and highest static level
    directed[n_dir++] = make_beat(MODE_ADD, 68, 1, -1);
    directed[n_dir++] = make_beat(MODE_ADD, 85, 4, -1);
    // expired add with a bad static level is dropped
    directed[n_dir++] = make_beat(MODE_ADD, 102, 0, -1);
    directed[n_dir++] = make_beat(MODE_ADD, 119, 5, -1);
    directed[n_dir++] = make_beat(MODE_ADD, 136, 7, -1);
    // dynamic levels below -1 are dropped
    directed[n_dir++] = make_beat(MODE_ADD, 153, 1, -2);
    directed[n_dir++] = make_beat(MODE_ADD, 170, 2, -3);
    directed[n_dir++] = make_beat(MODE_ADD, 187, 3, -4);
    // drain: highest level first, fifo order within a level, then the
    // active bank runs dry and the expired tasks come back after a swap
    repeat (9) directed[n_dir++] = make_beat(MODE_TAKE, 204, 7, 7);
    // both banks empty again
    directed[n_dir++] = make_beat(MODE_TAKE, 255, 4, 3);

    for (int i = 0; i < n_dir; i++) send_beat(directed[i]);

    // random phases with shifting add/take mix
    sent  = 0;
    phase = 0;
    while (sent < RAND_BEATS) begin
      case ($urandom_range(0, 4))
        0:       add_pct = 20;
        1:       add_pct = 40;
        2:       add_pct = 55;
        3:       add_pct = 75;
        default: add_pct = 92;
      endcase
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // long hold-off on the result side while adds keep coming
        add_pct       = 92;
        sender_idles  = 1'b0;
        receiver_hold = HOLD_CYCLES;
      end
      len = $urandom_range(40, 160);
      repeat (len) send_beat(random_beat(add_pct));
      sent += len;
      phase++;
    end

    @(negedge clk);
    req.valid = 1'b0;

    // let the last results arrive and the bench settle before the summary
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("covered %0d adds (%0d dropped, %0d on a full level), %0d takes",
             sb.n_adds, sb.n_drops, sb.n_full_drops, sb.n_takes);
    $display("takes finding nothing: %0d, bank swaps: %0d, cycles: %0d",
             sb.n_none, sb.n_swaps, cycle_count);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/tbq_pkg.sv
src/tbq_if.sv
src/tbq_ram.sv
src/tbq_ctrl.sv
src/two_bank_priority_ready_queue.sv
sim/tb_top.sv
